/* design/rdc_pkg.sv */
// Shared types and constants for the radix digit converter.
// No dependencies; the design files other than rdc_ram refer to it by scoped names.
package rdc_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int DIGIT_SLOTS_DEFAULT = 32;
   localparam int RADIX_WIDTH         = 16;
   localparam int POSITION_WIDTH      = 5;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 16'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 16'd2;

   // Status of the queue head as the back end sees it
   typedef struct packed {
      logic valid;
      logic is_zero;
   } head_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

endpackage

/* design/rdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rdc_front.sv */
// Front end: radix register, transaction accept, zero detect and a two-entry queue.
// Depends on rdc_pkg.
module rdc_front #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [VALUE_WIDTH-1:0]        req_value,
   input  logic                          csr_write_enable,
   input  logic [rdc_pkg::RADIX_WIDTH-1:0] csr_write_data,
   output logic [rdc_pkg::RADIX_WIDTH-1:0] radix,
   output rdc_pkg::head_type             head,
   output logic [VALUE_WIDTH-1:0]        head_value,
   input  logic                          pop
);

   logic [rdc_pkg::RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0]          value_q_ff [2];
   logic                            zero_q_ff  [2];
   logic                            wr_ptr_ff, wr_ptr_in;
   logic                            rd_ptr_ff, rd_ptr_in;
   logic [1:0]                      count_ff, count_in;
   logic                            push;

   // Clamp radix to two and above
   always_comb begin
      radix_in = radix_ff;
      if (csr_write_enable) begin
         radix_in = (csr_write_data < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN
                                                          : csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdc_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign radix = radix_ff;

   // Queue pointers and fill count
   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the value and its zero class
   always_ff @(posedge clock) begin
      if (push) begin
         value_q_ff[wr_ptr_ff] <= req_value;
         zero_q_ff[wr_ptr_ff]  <= (req_value == '0);
      end
   end

   assign head.valid   = (count_ff != 2'd0);
   assign head.is_zero = zero_q_ff[rd_ptr_ff];
   assign head_value   = value_q_ff[rd_ptr_ff];

endmodule

/* design/rdc_div.sv */
// Restoring divider, one quotient bit per cycle, for a value by a 16-bit radix.
// Depends on rdc_pkg.
module rdc_div #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            div_start,
   input  logic [VALUE_WIDTH-1:0]          dividend,
   input  logic [rdc_pkg::RADIX_WIDTH-1:0] divisor,
   output logic                            div_done,
   output logic [VALUE_WIDTH-1:0]          quotient,
   output logic [rdc_pkg::RADIX_WIDTH-1:0] remainder
);

   localparam int RW = rdc_pkg::RADIX_WIDTH;
   localparam int CNTW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [RW:0]            trial;
   logic [RW+1:0]          diff;
   logic                   last_step;

   // One shift-subtract step
   assign trial     = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff      = {1'b0, trial} - {2'b00, divisor};
   assign last_step = (cnt_ff == CNTW'(VALUE_WIDTH - 1));

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[RW+1]) begin
            rem_in = diff[RW-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[RW-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNTW'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* design/rdc_back.sv */
// Back end: runs the division loop, stacks remainders and emits digits MSB first.
// Depends on rdc_pkg, rdc_div and rdc_ram.
module rdc_back #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGIT_SLOTS = rdc_pkg::DIGIT_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rdc_pkg::RADIX_WIDTH-1:0]    radix,
   input  rdc_pkg::head_type                  head,
   input  logic [VALUE_WIDTH-1:0]             head_value,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic [rdc_pkg::RADIX_WIDTH-1:0]    rsp_digit,
   output logic [rdc_pkg::POSITION_WIDTH-1:0] rsp_position,
   output logic                               rsp_last_digit
);

   localparam int RW = rdc_pkg::RADIX_WIDTH;
   localparam int AW = $clog2(DIGIT_SLOTS);
   localparam int CW = $clog2(DIGIT_SLOTS + 1);
   localparam int PW = rdc_pkg::POSITION_WIDTH;

   rdc_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0]          n_ff, n_in;
   logic [CW-1:0]          k_ff, k_in;
   logic                   emit_ff, emit_in;
   logic [PW-1:0]          pos_ff;
   logic                   last_ff, last_in;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [RW-1:0]          div_remainder;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [RW-1:0]          wr_data;
   logic [AW-1:0]          rd_addr;
   logic [CW-1:0]          n_next;
   logic                   loop_end;
   logic                   emit_last;
   logic [CW-1:0]          rd_index;

   assign n_next    = n_ff + CW'(1);
   assign loop_end  = (div_quotient == '0) || (n_next == CW'(DIGIT_SLOTS));
   assign emit_last = (k_ff == n_ff - CW'(1));
   assign rd_index  = n_ff - CW'(1) - k_ff;

   rdc_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_start(div_start),
      .dividend (div_dividend),
      .divisor  (radix),
      .div_done (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   rdc_ram #(
      .WIDTH(RW),
      .DEPTH(DIGIT_SLOTS)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rsp_digit)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdc_pkg::BK_IDLE: begin
            if (head.valid) begin
               state_in = head.is_zero ? rdc_pkg::BK_EMIT : rdc_pkg::BK_DIVIDE;
            end
         end
         rdc_pkg::BK_DIVIDE: begin
            if (div_done && loop_end) begin
               state_in = rdc_pkg::BK_EMIT;
            end
         end
         rdc_pkg::BK_EMIT: begin
            if (emit_last) begin
               state_in = rdc_pkg::BK_IDLE;
            end
         end
         default: state_in = rdc_pkg::BK_IDLE;
      endcase
   end

   // Datapath controls per state
   always_comb begin
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = head_value;
      wr_en        = 1'b0;
      wr_addr      = n_ff[AW-1:0];
      wr_data      = div_remainder;
      rd_addr      = rd_index[AW-1:0];
      n_in         = n_ff;
      k_in         = k_ff;
      emit_in      = 1'b0;
      last_in      = 1'b0;
      case (state_ff)
         rdc_pkg::BK_IDLE: begin
            k_in = '0;
            if (head.valid) begin
               pop = 1'b1;
               if (head.is_zero) begin
                  // Zero gives a single digit 0
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = '0;
                  n_in    = CW'(1);
               end else begin
                  div_start = 1'b1;
                  n_in      = '0;
               end
            end
         end
         rdc_pkg::BK_DIVIDE: begin
            div_dividend = div_quotient;
            if (div_done) begin
               wr_en = 1'b1;
               n_in  = n_next;
               if (!loop_end) begin
                  div_start = 1'b1;
               end
            end
         end
         rdc_pkg::BK_EMIT: begin
            emit_in = 1'b1;
            last_in = emit_last;
            k_in    = k_ff + CW'(1);
         end
         default: begin
            n_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdc_pkg::BK_IDLE;
         n_ff     <= '0;
         k_ff     <= '0;
         emit_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         emit_ff  <= emit_in;
         last_ff  <= last_in;
      end
   end

   // Position travels alongside the registered stack read
   always_ff @(posedge clock) begin
      pos_ff <= PW'(k_ff);
   end

   assign rsp_strobe     = emit_ff;
   assign rsp_position   = pos_ff;
   assign rsp_last_digit = last_ff;

endmodule

/* design/radix_digit_converter_top.sv */
// Top level of the radix digit converter.
// Depends on rdc_pkg, rdc_front and rdc_back (which holds rdc_div and rdc_ram).
//
// Usage:
//   Input: drive req_value and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low. Two values can wait in
//   the front queue while an earlier one is being converted.
//   Configuration: csr_write_enable with csr_write_data writes the radix
//   (values 0 and 1 are stored as 2); write it only while the block is idle.
//   Output: one transaction per digit, most significant first, each shown for
//   one cycle under rsp_strobe with rsp_position and rsp_last_digit. The
//   digits of one value come in consecutive cycles.
// Timing: the shared bit-serial divider sets the rate. Each digit costs one
//   division, then the digits stream out one per cycle from the stack RAM.
//   A zero value skips the divider and gives a single digit 0.
// Reset: synchronous, active high; radix returns to 10, queue and sequencer
//   are emptied. The receiver cannot stall; results are never held back.
module radix_digit_converter_top #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGIT_SLOTS = rdc_pkg::DIGIT_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [VALUE_WIDTH-1:0]             req_value,
   input  logic                               csr_write_enable,
   input  logic [rdc_pkg::RADIX_WIDTH-1:0]    csr_write_data,
   output logic                               rsp_strobe,
   output logic [rdc_pkg::RADIX_WIDTH-1:0]    rsp_digit,
   output logic [rdc_pkg::POSITION_WIDTH-1:0] rsp_position,
   output logic                               rsp_last_digit
);

   logic [rdc_pkg::RADIX_WIDTH-1:0] radix;
   rdc_pkg::head_type               head;
   logic [VALUE_WIDTH-1:0]          head_value;
   logic                            pop;

   rdc_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .radix           (radix),
      .head            (head),
      .head_value      (head_value),
      .pop             (pop)
   );

   rdc_back #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DIGIT_SLOTS(DIGIT_SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix),
      .head          (head),
      .head_value    (head_value),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_digit     (rsp_digit),
      .rsp_position  (rsp_position),
      .rsp_last_digit(rsp_last_digit)
   );

   // Digits of one value stream without gaps
   a_digits_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_digit |=> rsp_strobe)
      else $error("digit stream broke before the last digit");

   // Positions count up by one within a value
   a_position_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_digit |=>
         rsp_position == rdc_pkg::POSITION_WIDTH'($past(rsp_position) + 1'b1))
      else $error("digit position did not advance by one");

   // Every digit lies below the radix
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit < radix)
      else $error("digit not below radix");

   // The queue head is taken only when present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

endmodule

/* tb/radix_digit_converter_top_test.sv */
// Self-checking testbench for radix_digit_converter_top: digit strings in a programmable base.
// Depends on rdc_pkg and the design files; a local digit predictor checks every digit.
module radix_digit_converter_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT;
   localparam int DIGIT_SLOTS = rdc_pkg::DIGIT_SLOTS_DEFAULT;
   localparam int RW          = rdc_pkg::RADIX_WIDTH;
   localparam int PW          = rdc_pkg::POSITION_WIDTH;
   // Slowest correct run: ~450 items of 32 digits each, plus sender gaps
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [RW-1:0] digit;
      logic [PW-1:0] position;
      logic          last_digit;
   } digit_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   csr_write_enable;
   logic [RW-1:0]          csr_write_data;
   logic                   rsp_strobe;
   logic [RW-1:0]          rsp_digit;
   logic [PW-1:0]          rsp_position;
   logic                   rsp_last_digit;

   logic [RW-1:0]     radix_setting;
   digit_result_type  expected_digits[$];
   int                failures;
   int                values_sent;
   int                digits_checked;
   int                radix_writes;
   int                cycle_count;

   radix_digit_converter_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_digit        (rsp_digit),
      .rsp_position     (rsp_position),
      .rsp_last_digit   (rsp_last_digit)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("radix_digit_converter_top verification failed");
         $finish;
      end
   end

   // Divide down by the radix, stack the remainders, queue them most significant first
   task automatic predict_digits(input logic [VALUE_WIDTH-1:0] value);
      logic [RW-1:0]          remainders[DIGIT_SLOTS];
      logic [VALUE_WIDTH-1:0] quotient;
      logic [VALUE_WIDTH-1:0] divisor;
      digit_result_type       item;
      int                     count;
      quotient = value;
      divisor  = VALUE_WIDTH'(radix_setting);
      count    = 0;
      if (quotient == '0) begin
         remainders[0] = '0;
         count = 1;
      end else begin
         while (quotient != '0 && count < DIGIT_SLOTS) begin
            remainders[count] = RW'(quotient % divisor);
            quotient = quotient / divisor;
            count++;
         end
      end
      for (int k = 0; k < count; k++) begin
         item.digit      = remainders[count - 1 - k];
         item.position   = PW'(k);
         item.last_digit = (k == count - 1);
         expected_digits.push_back(item);
      end
   endtask

   // Compare each digit transaction with the oldest expectation
   always @(posedge clock) begin
      digit_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected digit transaction: digit %0d position %0d last_digit %0b",
                   rsp_digit, rsp_position, rsp_last_digit);
            failures++;
         end else begin
            want = expected_digits.pop_front();
            digits_checked++;
            if (rsp_digit !== want.digit) begin
               $error("digit: expected %0d, actual %0d", want.digit, rsp_digit);
               failures++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_position);
               failures++;
            end
            if (rsp_last_digit !== want.last_digit) begin
               $error("last_digit: expected %0b, actual %0b", want.last_digit,
                      rsp_last_digit);
               failures++;
            end
         end
      end
   end

   // Offer one value and hold it until the block takes it
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      predict_digits(value);
      values_sent++;
   endtask

   // Drop start for a number of cycles
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending and wait until every digit has come out
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the radix; only called with the block idle
   task automatic write_radix(input logic [RW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      radix_setting = (data < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : data;
      radix_writes++;
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] base;
      base = VALUE_WIDTH'(radix_setting);
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = VALUE_WIDTH'($urandom_range(0, 255));
         2: v = VALUE_WIDTH'($urandom()) >> $urandom_range(1, 31);
         // around the one- to two-digit boundary
         3: v = base - 1 + VALUE_WIDTH'($urandom_range(0, 2));
         // around the two- to three-digit boundary
         4: v = base * base - VALUE_WIDTH'($urandom_range(0, 1));
         5: v = {VALUE_WIDTH{1'b1}} - VALUE_WIDTH'($urandom_range(0, 3));
         default: v = VALUE_WIDTH'($urandom());
      endcase
      return v;
   endfunction

   function automatic logic [RW-1:0] pick_radix();
      logic [RW-1:0] r;
      case ($urandom_range(0, 9))
         0: r = RW'($urandom_range(0, 3));
         1: r = 16'hFFFF - RW'($urandom_range(0, 15));
         2: r = 16'd10;
         3: r = 16'd16;
         4: r = 16'd8;
         default: r = RW'($urandom_range(4, 65535));
      endcase
      return r;
   endfunction

   // Reset radix of ten, edge values
   task automatic test_default_radix();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'hFFFF_FFFF);
      send_value(32'd1234567890);
      drain_block();
   endtask

   // Radix floor, smallest and largest bases, full-length digit strings
   task automatic test_radix_extremes();
      write_radix(16'd0);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      drain_block();
      write_radix(16'd1);
      send_value(32'd5);
      drain_block();
      write_radix(16'd2);
      send_value(32'd1);
      send_value(32'd0);
      drain_block();
      write_radix(16'hFFFF);
      send_value(32'd65534);
      send_value(32'd65535);
      send_value(32'd65536);
      send_value(32'hFFFF_FFFF);
      send_value(32'd0);
      drain_block();
      write_radix(16'd3);
      send_value(32'hFFFF_FFFF);
      send_value(32'h5555_5555);
      drain_block();
   endtask

   // Random bases and values with sender gaps
   task automatic test_random_phases(input int phases, input int per_phase);
      bit idle_on;
      for (int p = 0; p < phases; p++) begin
         write_radix(pick_radix());
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < per_phase; i++) begin
            if (idle_on && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 7));
            send_value(pick_value());
         end
         drain_block();
      end
   endtask

   // Closing stretch: values sent back to back
   task automatic test_back_to_back(input int count);
      write_radix(16'd10);
      for (int i = 0; i < count / 2; i++) send_value(pick_value());
      drain_block();
      write_radix(16'd16);
      for (int i = 0; i < count / 2; i++) send_value(pick_value());
      drain_block();
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_value        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      radix_setting    = rdc_pkg::RADIX_RESET;
      failures         = 0;
      values_sent      = 0;
      digits_checked   = 0;
      radix_writes     = 0;
      cycle_count      = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_radix();
      test_radix_extremes();
      test_random_phases(11, 32);
      test_back_to_back(48);

      $display("Converted %0d values into %0d checked digits over %0d radix writes.",
               values_sent, digits_checked, radix_writes);
      $display("Bases ranged from the floor of two up to 65535, including zero values.");
      if (failures == 0) begin
         $display("radix_digit_converter_top verification clean");
      end else begin
         $display("radix_digit_converter_top verification failed");
      end
      $finish;
   end

endmodule
